FILE: hdl/lct_pkg.sv
// shared constants and types for the lru cache table
package lct_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int IDX_BITS   = $clog2(ENTRIES);
	localparam int RANK_BITS  = $clog2(ENTRIES);
	localparam int OCC_BITS   = $clog2(ENTRIES + 1);
	localparam int CAP_BITS   = 5;
	localparam int EXT_BITS   = (CAP_BITS > OCC_BITS) ? CAP_BITS : OCC_BITS;

	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_INSERT = 1'b1;

	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [RANK_BITS-1:0]  rank_t;
	typedef logic [OCC_BITS-1:0]   occ_t;
	typedef logic [EXT_BITS-1:0]   ext_t;

endpackage

FILE: hdl/lru_cache_table.sv
// throughput: one request per cycle unless out_stall holds the result register;
//   input register, one pass of parallel key compare and rank update over all
//   entries, then the result register
// reset: clears valid marks, recency ranks and occupancy, capacity returns to 16;
//   key and value storage is not cleared and there is no clearing pass
module lru_cache_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lct_pkg::CAP_BITS-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       func,
	input  lct_pkg::key_t              key,
	input  lct_pkg::value_t            value_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       hit,
	output lct_pkg::value_t            value_out,
	output logic                       evicted
);
	import lct_pkg::*;

	logic [CAP_BITS-1:0] cap_q;

	logic   valid_s1;
	logic   func_s1;
	key_t   key_s1;
	value_t value_s1;

	logic   out_valid_q;
	logic   hit_q;
	value_t value_out_q;
	logic   evicted_q;

	key_t                entry_key_q   [ENTRIES];
	value_t              entry_value_q [ENTRIES];
	logic [ENTRIES-1:0]  entry_valid_q;
	rank_t               rank_q        [ENTRIES];
	occ_t                occ_q;

	logic advance, fire;
	logic [ENTRIES-1:0] match;
	logic found;
	idx_t hit_slot, free_slot, victim_slot, slot;
	rank_t hit_rank, oldest_rank;
	ext_t cap_ext, occ_ext, cap_eff;
	logic is_insert, full, do_evict, do_fill, do_promote, age_all;
	rank_t rank_d [ENTRIES];

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// capacity clamped to 1..ENTRIES
	assign cap_ext = EXT_BITS'(cap_q);
	assign occ_ext = EXT_BITS'(occ_q);
	always_comb begin
		priority if (cap_ext == '0) begin
			cap_eff = EXT_BITS'(1);
		end else if (cap_ext > EXT_BITS'(ENTRIES)) begin
			cap_eff = EXT_BITS'(ENTRIES);
		end else begin
			cap_eff = cap_ext;
		end
	end

	// valid ranks are always a permutation of 0..occupancy-1
	assign oldest_rank = RANK_BITS'(occ_q - occ_t'(1));

	always_comb begin
		hit_slot    = '0;
		free_slot   = '0;
		victim_slot = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			match[i] = entry_valid_q[i] && (entry_key_q[i] == key_s1);
			if (match[i]) begin
				hit_slot = idx_t'(i);
			end
			if (!entry_valid_q[i]) begin
				free_slot = idx_t'(i);
			end
			if (entry_valid_q[i] && rank_q[i] == oldest_rank) begin
				victim_slot = idx_t'(i);
			end
		end
	end

	assign found      = |match;
	assign hit_rank   = rank_q[hit_slot];
	assign is_insert  = (func_s1 == FUNC_INSERT);
	assign full       = (occ_ext >= cap_eff) && (occ_q != '0);
	assign do_evict   = is_insert && !found && full;
	assign do_fill    = is_insert && !found && !full;
	assign do_promote = found || is_insert;
	assign age_all    = !found;

	always_comb begin
		priority if (found) begin
			slot = hit_slot;
		end else if (full) begin
			slot = victim_slot;
		end else begin
			slot = free_slot;
		end
	end

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			rank_d[i] = rank_q[i];
			if (idx_t'(i) == slot) begin
				rank_d[i] = '0;
			end else if (entry_valid_q[i] && (age_all || rank_q[i] < hit_rank)) begin
				rank_d[i] = rank_q[i] + rank_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1  <= func;
			key_s1   <= key;
			value_s1 <= value_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			occ_q         <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (fire) begin
			if (do_promote) begin
				for (int i = 0; i < ENTRIES; i++) begin
					rank_q[i] <= rank_d[i];
				end
			end
			if (do_fill) begin
				entry_valid_q[slot] <= 1'b1;
				occ_q               <= occ_q + occ_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_insert) begin
			entry_value_q[slot] <= value_s1;
			if (!found) begin
				entry_key_q[slot] <= key_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hit_q       <= found;
			value_out_q <= (found && !is_insert) ? entry_value_q[hit_slot] : '0;
			evicted_q   <= do_evict;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign value_out = value_out_q;
	assign evicted   = evicted_q;

`ifndef SYNTHESIS
	a_occ_tracks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(entry_valid_q) == int'(occ_q))
		else $error("occupancy does not match valid marks");

	a_evict_keeps_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && do_evict) |=> $stable(occ_q))
		else $error("eviction changed occupancy");

	a_evict_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && evicted_q) |-> !hit_q)
		else $error("eviction flagged on a hit");

	a_miss_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !hit_q) |-> (value_out_q == '0))
		else $error("nonzero value on a miss");
`endif

endmodule

FILE: test/lru_reply_checker.sv
// reply checker for the lru cache table: tracks every request and compares each reply
module lru_reply_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [lct_pkg::CAP_BITS-1:0] cfg_wdata,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic                         func,
	input  lct_pkg::key_t                key,
	input  lct_pkg::value_t              value_in,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic                         hit,
	input  lct_pkg::value_t              value_out,
	input  logic                         evicted,
	output int                           mismatches,
	output int                           outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import lct_pkg::*;

	typedef struct packed {
		logic   hit;
		value_t value_out;
		logic   evicted;
	} cache_reply_t;

	key_t                slot_key   [ENTRIES];
	value_t              slot_value [ENTRIES];
	logic                slot_used  [ENTRIES];
	rank_t               slot_age   [ENTRIES];
	int                  used_count;
	logic [CAP_BITS-1:0] capacity;
	cache_reply_t        expected_replies [$];
	cache_reply_t        oldest_reply;

	// slot s becomes newest; every used slot younger than limit ages by one
	function automatic void make_newest(int s, int limit);
		for (int i = 0; i < ENTRIES; i++)
			if (slot_used[i] && i != s && int'(slot_age[i]) < limit)
				slot_age[i]++;
		slot_age[s] = '0;
	endfunction

	function automatic cache_reply_t apply_request(logic f, key_t k, value_t v);
		cache_reply_t r;
		int           lim;
		int           slot;
		int           oldest;
		logic         found;
		r = '0;
		found = 1'b0;
		slot = 0;
		lim = int'(capacity);
		if (lim == 0)
			lim = 1;
		if (lim > ENTRIES)
			lim = ENTRIES;
		for (int i = 0; i < ENTRIES; i++)
			if (!found && slot_used[i] && slot_key[i] == k) begin
				found = 1'b1;
				slot = i;
			end
		r.hit = found;
		if (found) begin
			if (f == FUNC_LOOKUP)
				r.value_out = slot_value[slot];
			else
				slot_value[slot] = v;
			make_newest(slot, int'(slot_age[slot]));
		end else if (f == FUNC_INSERT) begin
			if (used_count >= lim) begin
				// table full for this capacity: the oldest entry gives up its slot
				oldest = -1;
				for (int i = 0; i < ENTRIES; i++)
					if (slot_used[i] && (oldest < 0 || slot_age[i] > slot_age[oldest]))
						oldest = i;
				slot = oldest;
				r.evicted = 1'b1;
				make_newest(slot, ENTRIES);
			end else begin
				// lowest free slot
				for (int i = ENTRIES - 1; i >= 0; i--)
					if (!slot_used[i])
						slot = i;
				slot_used[slot] = 1'b1;
				used_count++;
				make_newest(slot, ENTRIES);
			end
			slot_key[slot] = k;
			slot_value[slot] = v;
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [VALUE_BITS-1:0] want,
			logic [VALUE_BITS-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				slot_key[i] = '0;
				slot_value[i] = '0;
				slot_used[i] = 1'b0;
				slot_age[i] = '0;
			end
			used_count = 0;
			capacity = CAP_RESET;
			expected_replies.delete();
			mismatches = 0;
		end else begin
			if (cfg_we)
				capacity = cfg_wdata;
			if (in_valid && !in_stall)
				expected_replies.push_back(apply_request(func, key, value_in));
			if (out_valid && !out_stall) begin
				if (expected_replies.size() == 0) begin
					mismatches++;
					$display("%0t ns: unexpected reply, expected none, %s %0b %0h %0b",
						$time, "got hit/value/evicted", hit, value_out, evicted);
				end else begin
					oldest_reply = expected_replies.pop_front();
					check_field("hit", VALUE_BITS'(oldest_reply.hit), VALUE_BITS'(hit));
					check_field("value_out", oldest_reply.value_out, value_out);
					check_field("evicted", VALUE_BITS'(oldest_reply.evicted),
						VALUE_BITS'(evicted));
				end
			end
		end
		outstanding = expected_replies.size();
	end

endmodule

FILE: test/tb_lru_cache_table.sv
// testbench top for the lru cache table: reset, capacity phases, request and stall stimulus
module tb_lru_cache_table;
	timeunit 1ns;
	timeprecision 1ps;
	import lct_pkg::*;

	localparam int RESET_CYCLES = 6;
	localparam int POOL_SIZE    = 40;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 125;
	localparam int HOLD_CYCLES  = 48;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CAP_BITS-1:0] cfg_wdata;
	logic                in_valid;
	logic                in_stall;
	logic                func;
	key_t                key;
	value_t              value_in;
	logic                out_valid;
	logic                out_stall;
	logic                hit;
	value_t              value_out;
	logic                evicted;

	int   mismatches;
	int   outstanding;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   hold_request   = 0;
	int   pool_n         = 2;
	key_t key_pool [POOL_SIZE];

	lru_cache_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.key       (key),
		.value_in  (value_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.value_out (value_out),
		.evicted   (evicted)
	);

	lru_reply_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.key         (key),
		.value_in    (value_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.value_out   (value_out),
		.evicted     (evicted),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver: random stalls, or a long hold-off when one is requested
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				out_stall <= 1'b1;
				hold_request--;
			end else
				out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic send_request(input logic f, input key_t k, input value_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		key <= k;
		value_in <= v;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_BITS-1:0] c);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic key_t pick_key();
		if ($urandom_range(9) == 0)
			return $urandom;
		return key_pool[$urandom_range(pool_n - 1)];
	endfunction

	initial begin
		int cap;
		int eff;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		func <= FUNC_LOOKUP;
		key <= '0;
		value_in <= '0;
		foreach (key_pool[i])
			key_pool[i] = $urandom;
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(FUNC_LOOKUP, '0, '1);
		send_request(FUNC_INSERT, '0, '1);
		send_request(FUNC_INSERT, '1, '0);
		send_request(FUNC_LOOKUP, '0, '0);
		send_request(FUNC_LOOKUP, '1, '1);
		// insert of a present key updates the value and makes the entry newest
		send_request(FUNC_INSERT, '0, 32'h1234_5678);
		send_request(FUNC_LOOKUP, '0, '0);
		for (int i = 2; i < 7; i++)
			send_request(FUNC_INSERT, key_pool[i], $urandom);
		// capacity below occupancy: each new key takes over the oldest slot
		write_capacity(5'd2);
		send_request(FUNC_INSERT, key_pool[7], $urandom);
		send_request(FUNC_INSERT, key_pool[8], $urandom);
		send_request(FUNC_LOOKUP, '1, '0);
		send_request(FUNC_LOOKUP, key_pool[8], '0);
		write_capacity(5'd0);
		send_request(FUNC_INSERT, key_pool[9], $urandom);
		send_request(FUNC_LOOKUP, key_pool[9], '0);
		send_request(FUNC_LOOKUP, key_pool[8], '0);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: cap = 16;
				1: cap = 1;
				2: cap = 0;
				3: cap = 31;
				4: cap = 17;
				5: cap = 2;
				default: cap = $urandom_range(31);
			endcase
			write_capacity(CAP_BITS'(cap));
			eff = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : cap);
			// key pool of 2 to 2*eff+2 keys, so hits and evictions can both occur
			pool_n = $urandom_range(eff * 2 + 2, 2);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 88;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 88;
				end
				default: begin
					send_idle_pct = 13;
					recv_stall_pct = 13;
				end
			endcase
			if (p == 0)
				hold_request = HOLD_CYCLES;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					wait_drained();
				send_request(1'($urandom_range(1)), pick_key(), $urandom);
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/lct_pkg.sv
hdl/lru_cache_table.sv
test/lru_reply_checker.sv
test/tb_lru_cache_table.sv
